[hdl/route_table_best_metric_unit_macros.svh]
// assertion helpers for the route table block
`ifndef ROUTE_TABLE_BEST_METRIC_UNIT_MACROS_SVH
`define ROUTE_TABLE_BEST_METRIC_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RTBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RTBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rtbm_pkg.sv]
package rtbm_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 16;
  localparam int PORT_COUNT = 16;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_FIND = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [15:0] address;
    logic [3:0]  port;
    logic [15:0] cost;
  } entry_t;

endpackage

[hdl/rtbm_ram.sv]
module rtbm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/route_table_best_metric_unit.sv]
// channel   direction  handshake            fields
// command   in         start, busy          mode, dest_address, port_number, link_cost
// result    out        done (one cycle)     status, hit, found_port
//
// an item is accepted in ST_IDLE and steps through ST_SCAN, ST_LAST and ST_FINISH to
// done; the scan reads the route memory through its single registered read port
// busy is high from ST_SCAN through ST_FINISH; a new start is taken while done shows
// rst clears the state, the route valid bits and done; the route memory is not cleared
// results cannot be held off: done is high for exactly one cycle per item
module route_table_best_metric_unit #(
  parameter int TABLE_ENTRIES = rtbm_pkg::TABLE_ENTRIES_DEFAULT,
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [15:0] dest_address,
  input  logic [3:0]  port_number,
  input  logic [15:0] link_cost,
  output logic        done,
  output logic [1:0]  status,
  output logic        hit,
  output logic [3:0]  found_port
);

  localparam int EntryW = $bits(rtbm_pkg::entry_t);

  rtbm_pkg::state_t state, state_next;

  logic [TABLE_ENTRIES-1:0] valid;

  logic        mode_q;
  logic [15:0] addr_q;
  logic [3:0]  port_q;
  logic [15:0] cost_q;

  logic [IdxW-1:0] scan_idx;
  logic [IdxW-1:0] cmp_idx;
  logic            cmp_valid;

  logic            match_found;
  logic [IdxW-1:0] match_idx;
  logic [3:0]      match_port;
  logic [15:0]     match_cost;
  logic            free_found;
  logic [IdxW-1:0] free_idx;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  rtbm_pkg::entry_t  ram_wentry;
  logic [EntryW-1:0] ram_rdata;
  rtbm_pkg::entry_t  rd_entry;

  logic       res_insert;
  logic [1:0] res_status;
  logic [3:0] res_port;

  logic scan_last;
  logic port_ok;
  logic cmp_hit;
  logic cmp_free;

  rtbm_ram #(
    .WIDTH(EntryW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(EntryW'(ram_wentry)),
    .raddr(scan_idx),
    .rdata(ram_rdata)
  );

  assign rd_entry  = rtbm_pkg::entry_t'(ram_rdata);
  assign scan_last = (scan_idx == IdxW'(TABLE_ENTRIES - 1));
  assign port_ok   = (int'(port_q) < rtbm_pkg::PORT_COUNT);
  assign cmp_hit   = cmp_valid && valid[cmp_idx] && (rd_entry.address == addr_q);
  assign cmp_free  = cmp_valid && !valid[cmp_idx];

  always_comb begin
    state_next = state;
    case (state)
      rtbm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = rtbm_pkg::ST_SCAN;
        end
      end
      rtbm_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = rtbm_pkg::ST_LAST;
        end
      end
      rtbm_pkg::ST_LAST: begin
        state_next = rtbm_pkg::ST_FINISH;
      end
      rtbm_pkg::ST_FINISH: begin
        state_next = rtbm_pkg::ST_IDLE;
      end
      default: begin
        state_next = rtbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy               = (state != rtbm_pkg::ST_IDLE);
    ram_we             = 1'b0;
    ram_waddr          = match_idx;
    ram_wentry.address = addr_q;
    ram_wentry.port    = port_q;
    ram_wentry.cost    = cost_q;
    res_insert         = 1'b0;
    res_status         = rtbm_pkg::STATUS_OK;
    res_port           = 4'd0;
    if (state == rtbm_pkg::ST_FINISH) begin
      if (mode_q == rtbm_pkg::MODE_FIND) begin
        if (match_found) begin
          res_port = match_port;
        end else begin
          res_status = rtbm_pkg::STATUS_NOT_FOUND;
        end
      end else if (match_found) begin
        ram_we = port_ok && (cost_q < match_cost);
      end else if (!free_found) begin
        res_status = rtbm_pkg::STATUS_FULL;
      end else begin
        ram_waddr  = free_idx;
        ram_we     = port_ok;
        res_insert = port_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rtbm_pkg::ST_IDLE;
      valid     <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rtbm_pkg::ST_FINISH);
      if (res_insert) begin
        valid[ram_waddr] <= 1'b1;
      end
      cmp_valid <= (state == rtbm_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == rtbm_pkg::ST_IDLE && start) begin
      mode_q      <= mode;
      addr_q      <= dest_address;
      port_q      <= port_number;
      cost_q      <= link_cost;
      scan_idx    <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (state == rtbm_pkg::ST_SCAN) begin
        scan_idx <= scan_idx + IdxW'(1);
      end
      if (cmp_hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= cmp_idx;
        match_port  <= rd_entry.port;
        match_cost  <= rd_entry.cost;
      end
      if (cmp_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
    cmp_idx <= scan_idx;
    if (state == rtbm_pkg::ST_FINISH) begin
      status     <= res_status;
      hit        <= match_found;
      found_port <= res_port;
    end
  end

endmodule

[hdl/rtbm_checker.sv]
`include "route_table_best_metric_unit_macros.svh"

module rtbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        hit,
  input logic [3:0]  found_port
);

  `RTBM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `RTBM_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
  `RTBM_ASSERT_NOW(a_miss_no_hit, done && status != rtbm_pkg::STATUS_OK, !hit, "error with hit")
  `RTBM_ASSERT_NOW(a_port_on_ok, done && status != rtbm_pkg::STATUS_OK, found_port == 4'd0,
                   "port on error result")
  `RTBM_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

bind route_table_best_metric_unit rtbm_checker u_rtbm_checker (.*);
